// ----- design/assert_macros.svh -----
// Assertion helpers for the design folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ----- design/pqot_pkg.sv -----
package pqot_pkg;
    localparam int MaxVertices = 64;
    localparam int IdxW = $clog2(MaxVertices);
    localparam int CntW = $clog2(MaxVertices + 1);
    localparam int CrdW = 32;
    localparam int DifW = 34;
    localparam logic signed [DifW-1:0] RayLen = DifW'(64'sd5000000 * 64'sd256);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEST   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic signed [CrdW-1:0] x;
        logic signed [CrdW-1:0] y;
    } t_pt;

    typedef struct packed {
        t_cmd                   cmd;
        logic signed [CrdW-1:0] vertex_x;
        logic signed [CrdW-1:0] vertex_y;
        logic signed [CrdW-1:0] corner0_x;
        logic signed [CrdW-1:0] corner0_y;
        logic signed [CrdW-1:0] corner1_x;
        logic signed [CrdW-1:0] corner1_y;
        logic signed [CrdW-1:0] corner2_x;
        logic signed [CrdW-1:0] corner2_y;
        logic signed [CrdW-1:0] corner3_x;
        logic signed [CrdW-1:0] corner3_y;
    } t_req;

    typedef struct packed {
        logic overlaps;
        logic append_dropped;
    } t_res;

    // controller -> datapath
    typedef struct packed {
        logic            load_box;   // capture box corners
        logic            write_pt;   // store vertex at count
        logic            rd_en;      // issue memory read
        logic [IdxW-1:0] rd_addr;
        logic            first;      // read data is point 0 (prime)
        logic            edge_v;     // an edge is at the product stage
        logic            pray;       // run the point-0 ray test
        logic            clr_acc;
    } t_cmdbus;

    // datapath -> controller
    typedef struct packed {
        logic hit;   // some edge crossing seen
        logic odd;   // box-ray crossing parity, OR-ed with point-0 ray parity
    } t_stat;

    // exact sign of a*b - c*d, operands 34-bit signed
    function automatic logic signed [1:0] sgn_of(input logic signed [2*DifW:0] v);
        logic signed [1:0] s;
        s = (v > 0) ? 2'sd1 : ((v < 0) ? -2'sd1 : 2'sd0);
        return s;
    endfunction
endpackage

// ----- design/pqot_datapath.sv -----
`include "assert_macros.svh"
module pqot_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pqot_pkg::t_req     i_req,
    input  pqot_pkg::t_cmdbus  i_cmd,
    input  logic [pqot_pkg::IdxW-1:0] i_wr_addr,
    output pqot_pkg::t_stat    o_stat
);
    import pqot_pkg::*;

    t_pt r_mem [MaxVertices];
    t_pt r_rd;
    t_pt r_box [4];
    t_pt r_prev, r_cur, r_p0;
    logic r_rd_v, r_first_d;
    logic r_hit, r_odd;
    // registered products: 4 box edges + box ray, each side needs 4 products
    logic signed [2*DifW:0] r_pr [5][4];
    logic r_pv;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_pt) r_mem[i_wr_addr] <= t_pt'{x: i_req.vertex_x, y: i_req.vertex_y};
        if (i_cmd.rd_en) r_rd <= r_mem[i_cmd.rd_addr];
        if (i_cmd.load_box) begin
            r_box[0] <= t_pt'{x: i_req.corner0_x, y: i_req.corner0_y};
            r_box[1] <= t_pt'{x: i_req.corner1_x, y: i_req.corner1_y};
            r_box[2] <= t_pt'{x: i_req.corner2_x, y: i_req.corner2_y};
            r_box[3] <= t_pt'{x: i_req.corner3_x, y: i_req.corner3_y};
        end
    end

    // seed read (last point) lands in cur; each later read shifts cur into prev
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.rd_en;
        end
        r_first_d <= i_cmd.first;
        if (r_rd_v) begin
            if (r_first_d) r_p0 <= r_rd;
            r_prev <= r_cur;
            r_cur  <= r_rd;
        end
    end

    // cross(q1-q0, x-q0) terms a*b and c*d
    function automatic logic signed [2*DifW:0] mulx(input logic signed [DifW-1:0] a,
                                                    input logic signed [DifW-1:0] b);
        return (2*DifW+1)'(a * b);
    endfunction

    // stage A: products. P = cur->prev, Q = box edge or box ray
    logic signed [DifW-1:0] n_qx0 [5], n_qy0 [5], n_qx1 [5], n_qy1 [5];
    logic signed [2*DifW:0] n_pr [5][4];
    logic signed [DifW-1:0] pcx, pcy, ppx, ppy;

    always_comb begin
        pcx = DifW'(r_cur.x); pcy = DifW'(r_cur.y);
        ppx = DifW'(r_prev.x); ppy = DifW'(r_prev.y);
        for (int k = 0; k < 5; k++) begin
            if (k < 4) begin
                n_qx0[k] = DifW'(r_box[k].x);       n_qy0[k] = DifW'(r_box[k].y);
                n_qx1[k] = DifW'(r_box[(k+1)%4].x); n_qy1[k] = DifW'(r_box[(k+1)%4].y);
            end else begin
                n_qx0[k] = DifW'(r_box[0].x);       n_qy0[k] = DifW'(r_box[0].y);
                n_qx1[k] = DifW'(r_box[0].x);       n_qy1[k] = DifW'(r_box[0].y) + RayLen;
            end
            // in pray mode the products are zeroed; the point-0 ray test runs in its own block
            if (i_cmd.pray) begin
                n_pr[k][0] = '0; n_pr[k][1] = '0; n_pr[k][2] = '0; n_pr[k][3] = '0;
            end else begin
                // s(P0): cross(Q1-Q0, cur-Q0); s(P1) with prev; t via same layout
                n_pr[k][0] = mulx(n_qx1[k]-n_qx0[k], pcy-n_qy0[k])
                           - mulx(n_qy1[k]-n_qy0[k], pcx-n_qx0[k]);
                n_pr[k][1] = mulx(n_qx1[k]-n_qx0[k], ppy-n_qy0[k])
                           - mulx(n_qy1[k]-n_qy0[k], ppx-n_qx0[k]);
                n_pr[k][2] = mulx(ppx-pcx, n_qy0[k]-pcy) - mulx(ppy-pcy, n_qx0[k]-pcx);
                n_pr[k][3] = mulx(ppx-pcx, n_qy1[k]-pcy) - mulx(ppy-pcy, n_qx1[k]-pcx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pv <= 1'b0;
        else          r_pv <= i_cmd.edge_v;
        for (int k = 0; k < 5; k++)
            for (int j = 0; j < 4; j++) r_pr[k][j] <= n_pr[k][j];
    end

    // point-0 ray vs box edges, evaluated in one pass (4 small checks)
    logic n_podd;
    logic signed [DifW-1:0] rx0, ry0, ry1;
    always_comb begin
        logic signed [1:0] sa, sb, ta, tb;
        logic signed [DifW-1:0] ax, ay, bx, by;
        n_podd = 1'b0;
        rx0 = DifW'(r_p0.x); ry0 = DifW'(r_p0.y); ry1 = DifW'(r_p0.y) + RayLen;
        for (int k = 0; k < 4; k++) begin
            ax = DifW'(r_box[k].x); ay = DifW'(r_box[k].y);
            bx = DifW'(r_box[(k+1)%4].x); by = DifW'(r_box[(k+1)%4].y);
            sa = sgn_of(mulx(bx-ax, ry0-ay) - mulx(by-ay, rx0-ax));
            sb = sgn_of(mulx(bx-ax, ry1-ay) - mulx(by-ay, rx0-ax));
            ta = sgn_of(mulx(ry0-ry1, ax-rx0));
            tb = sgn_of(mulx(ry0-ry1, bx-rx0));
            ta = -ta; tb = -tb;
            if ((sa * sb < 0) && !(ta * tb > 0)) n_podd = ~n_podd;
        end
    end

    // stage B: sign evaluation and accumulate
    logic n_ehit, n_rx;
    always_comb begin
        logic signed [1:0] sa, sb, ta, tb;
        n_ehit = 1'b0; n_rx = 1'b0;
        for (int k = 0; k < 5; k++) begin
            sa = sgn_of(r_pr[k][0]); sb = sgn_of(r_pr[k][1]);
            ta = sgn_of(r_pr[k][2]); tb = sgn_of(r_pr[k][3]);
            if ((sa * sb < 0) && !(ta * tb > 0)) begin
                if (k < 4) n_ehit = 1'b1;
                else       n_rx   = 1'b1;
            end
        end
    end

    // box-ray parity first; an odd point-0 ray count also reports overlap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_acc) begin
            r_hit <= 1'b0;
            r_odd <= 1'b0;
        end else if (i_cmd.pray) begin
            r_odd <= r_odd | n_podd;
        end else if (r_pv) begin
            r_hit <= r_hit | n_ehit;
            r_odd <= r_odd ^ n_rx;
        end
    end

    assign o_stat = t_stat'{hit: r_hit, odd: r_odd};

    `ASSERT_NEXT(a_clr, i_clk, i_rst_n, i_cmd.clr_acc, !r_hit && !r_odd)
    `ASSERT_NEXT(a_rdv, i_clk, i_rst_n, i_cmd.rd_en, r_rd_v)
    `ASSERT_IMPLIES(a_excl, i_clk, i_rst_n, i_cmd.write_pt, !i_cmd.rd_en)
endmodule

// ----- design/pqot_ctrl.sv -----
`include "assert_macros.svh"
module pqot_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  pqot_pkg::t_cmd     i_cmd,
    input  pqot_pkg::t_stat    i_stat,
    output pqot_pkg::t_cmdbus  o_cmd,
    output logic [pqot_pkg::IdxW-1:0] o_wr_addr,
    output logic               o_busy,
    output logic               o_done,
    output pqot_pkg::t_res     o_res
);
    import pqot_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PRIME = 5'b00010,
        S_WALK  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_PRAY  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] r_idx, n_idx;
    logic [1:0] r_drain, n_drain;
    logic r_ovf;
    logic r_done, n_done;
    t_res r_res, n_res;
    logic acc;

    assign acc = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);
    assign o_wr_addr = r_count[IdxW-1:0];

    always_comb begin
        n_state = r_state; n_idx = r_idx; n_drain = r_drain;
        n_done = 1'b0; n_res = r_res;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_cmd)
                        CMD_APPEND: begin
                            n_done = 1'b1;
                            n_res = t_res'{overlaps: 1'b0,
                                           append_dropped: (r_count == CntW'(MaxVertices))};
                            o_cmd.write_pt = (r_count != CntW'(MaxVertices));
                        end
                        CMD_TEST: begin
                            o_cmd.load_box = 1'b1;
                            o_cmd.clr_acc  = 1'b1;
                            if (r_count < CntW'(2)) begin
                                n_done = 1'b1;
                                n_res = t_res'{overlaps: 1'b0, append_dropped: r_ovf};
                            end else begin
                                // read last point first as the seed "prev"
                                o_cmd.rd_en   = 1'b1;
                                o_cmd.rd_addr = IdxW'(r_count - CntW'(1));
                                n_idx = '0;
                                n_state = S_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_idx[IdxW-1:0];
                o_cmd.first   = (r_idx == '0);
                n_idx = r_idx + CntW'(1);
                if (n_idx == r_count) begin
                    n_state = S_DRAIN;
                    n_drain = 2'd0;
                end
            end
            S_DRAIN: begin
                n_drain = r_drain + 2'd1;
                if (r_drain == 2'd2) n_state = S_PRAY;
            end
            S_PRAY: begin
                o_cmd.pray = 1'b1;
                n_state = S_PRIME;
            end
            S_PRIME: begin
                n_done = 1'b1;
                n_res = t_res'{overlaps: i_stat.hit | i_stat.odd, append_dropped: r_ovf};
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // edge is valid at product stage when cur and prev hold a real pair:
    // the cycle after a non-seed read lands
    logic r_rd1, r_e;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd1 <= 1'b0; r_e <= 1'b0;
        end else begin
            r_rd1 <= o_cmd.rd_en && (r_state == S_WALK);
            r_e   <= r_rd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_ovf <= 1'b0;
            r_idx <= '0; r_drain <= '0; r_done <= 1'b0;
        end else begin
            r_state <= n_state; r_idx <= n_idx; r_drain <= n_drain; r_done <= n_done;
            if (acc && i_cmd == CMD_CLEAR) begin
                r_count <= '0; r_ovf <= 1'b0;
            end else if (acc && i_cmd == CMD_APPEND) begin
                if (r_count == CntW'(MaxVertices)) r_ovf <= 1'b1;
                else r_count <= r_count + CntW'(1);
            end
        end
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    `ASSERT_IMPLIES(a_cnt, i_clk, i_rst_n, 1'b1, r_count <= CntW'(MaxVertices))
    `ASSERT_NEXT(a_idle_acc, i_clk, i_rst_n, acc && i_cmd == CMD_TEST && r_count >= CntW'(2),
                 r_state == S_WALK)
    `ASSERT_IMPLIES(a_pray, i_clk, i_rst_n, o_cmd.pray, !r_e)
endmodule

// ----- design/polygon_quad_overlap_test.sv -----
// Channel   | Dir | Handshake              | Payload
// request   | in  | i_start / o_busy       | i_req (t_req)
// result    | out | o_done (1-cycle strobe)| o_res (t_res)
//
// Clear gives no result. Append gives its result in the cycle after
// acceptance. A test with n >= 2 stored points keeps o_busy high while it
// reads each polygon point from memory in turn (single read port), lets the
// read, pair and product pipeline empty, runs the point-0 ray check and
// reports; its result strobes in the first cycle with o_busy low again.
// A test with fewer than 2 points answers like an append.
// Reset is synchronous, active low; the point store is not cleared.
// The receiver cannot stall: o_done lasts exactly one cycle.
`include "assert_macros.svh"
module polygon_quad_overlap_test (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  pqot_pkg::t_req i_req,
    output logic           o_busy,
    output logic           o_done,
    output pqot_pkg::t_res o_res
);
    import pqot_pkg::*;

    t_cmdbus cmd_bus, cmd_q;
    t_stat   stat;
    logic [IdxW-1:0] wr_addr;
    logic r_e1, r_e2;

    pqot_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start, .i_cmd(i_req.cmd), .i_stat(stat),
        .o_cmd(cmd_bus), .o_wr_addr(wr_addr), .o_busy, .o_done, .o_res
    );

    // read issued in WALK (non-seed): data lands in the read register, then in cur/prev, then in the products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1 <= 1'b0; r_e2 <= 1'b0;
        end else begin
            r_e1 <= cmd_bus.rd_en && !cmd_bus.load_box;
            r_e2 <= r_e1;
        end
    end

    always_comb begin
        cmd_q = cmd_bus;
        cmd_q.edge_v = r_e2;
    end

    pqot_datapath u_dp (
        .i_clk, .i_rst_n, .i_req, .i_cmd(cmd_q), .i_wr_addr(wr_addr), .o_stat(stat)
    );

    `ASSERT_NEXT(a_edge_pipe, i_clk, i_rst_n, r_e1, r_e2)
    `ASSERT_IMPLIES(a_edge_no_pray, i_clk, i_rst_n, r_e2, !cmd_bus.pray)
    `ASSERT_IMPLIES(a_busy_done, i_clk, i_rst_n, o_done && o_busy, 1'b0)
endmodule

// ----- bench/polygon_quad_overlap_test_tb.sv -----
`timescale 1ns / 100ps
module polygon_quad_overlap_test_tb;
    import pqot_pkg::*;

    // Coordinate range for the random polygons and boxes, watchdog limit and drain length.
    localparam int NEAR_SPAN = 4000;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 100;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_done;
    t_res o_res;

    polygon_quad_overlap_test dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Shadow of the block state, kept by the predictor.
    t_pt         shape_pts[MaxVertices];
    int          shape_len;
    logic        shape_overflow;

    t_res        pending_res[$];
    int          fail_count;
    int          idle_cycles;
    bit          timed_out;

    task automatic report_mismatch(input string what, input t_res got, input t_res want);
        $display("MISMATCH %s: got ovl=%0b drop=%0b want ovl=%0b drop=%0b at %0t",
                 what, got.overlaps, got.append_dropped,
                 want.overlaps, want.append_dropped, $realtime);
        fail_count++;
    endtask

    // Points are held 64-bit wide here so the ray end can leave the 32-bit range.
    typedef struct {
        longint x;
        longint y;
    } wide_pt_t;

    function automatic int wide_side(input wide_pt_t p, input wide_pt_t q, input wide_pt_t r);
        logic signed [127:0] ax, ay, bx, by, v;
        ax = 128'(q.x) - 128'(p.x);
        ay = 128'(q.y) - 128'(p.y);
        bx = 128'(r.x) - 128'(p.x);
        by = 128'(r.y) - 128'(p.y);
        v = ax * by - ay * bx;
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // Asymmetric crossing rule: strict on the first segment's ends, closed on the second.
    function automatic bit segments_cross(input wide_pt_t p0, input wide_pt_t p1,
                                          input wide_pt_t q0, input wide_pt_t q1);
        int sa, sb, ta, tb;
        sa = wide_side(q0, q1, p0);
        sb = wide_side(q0, q1, p1);
        ta = wide_side(p0, p1, q0);
        tb = wide_side(p0, p1, q1);
        if (sa * sb >= 0) return 1'b0;
        if (ta * tb > 0) return 1'b0;
        return 1'b1;
    endfunction

    function automatic wide_pt_t widen(input t_pt p);
        wide_pt_t w;
        w.x = longint'(p.x);
        w.y = longint'(p.y);
        return w;
    endfunction

    function automatic bit box_overlaps_shape(input t_req r);
        wide_pt_t box[4];
        wide_pt_t prv, cur, ray_end;
        bit odd;
        box[0] = '{longint'(r.corner0_x), longint'(r.corner0_y)};
        box[1] = '{longint'(r.corner1_x), longint'(r.corner1_y)};
        box[2] = '{longint'(r.corner2_x), longint'(r.corner2_y)};
        box[3] = '{longint'(r.corner3_x), longint'(r.corner3_y)};
        odd = 1'b0;
        if (shape_len < 2) return 1'b0;
        prv = widen(shape_pts[shape_len-1]);
        for (int i = 0; i < shape_len; i++) begin
            cur = widen(shape_pts[i]);
            for (int k = 0; k < 4; k++)
                if (segments_cross(cur, prv, box[k], box[(k+1)%4])) return 1'b1;
            prv = cur;
        end
        // Upward ray from box corner 0 against the polygon.
        ray_end = box[0];
        ray_end.y += longint'(5000000) * 256;
        prv = widen(shape_pts[shape_len-1]);
        for (int i = 0; i < shape_len; i++) begin
            cur = widen(shape_pts[i]);
            if (segments_cross(cur, prv, box[0], ray_end)) odd = !odd;
            prv = cur;
        end
        if (odd) return 1'b1;
        // Upward ray from polygon point 0 against the box; ray is first segment.
        cur = widen(shape_pts[0]);
        ray_end = cur;
        ray_end.y += longint'(5000000) * 256;
        for (int k = 0; k < 4; k++)
            if (segments_cross(cur, ray_end, box[k], box[(k+1)%4])) odd = !odd;
        return odd;
    endfunction

    // Updates the shadow state and queues the result a request will produce.
    task automatic predict_request(input t_req r);
        t_res res;
        case (r.cmd)
            CMD_CLEAR: begin
                shape_len = 0;
                shape_overflow = 1'b0;
            end
            CMD_APPEND: begin
                res.overlaps = 1'b0;
                res.append_dropped = 1'b0;
                if (shape_len < MaxVertices) begin
                    shape_pts[shape_len].x = r.vertex_x;
                    shape_pts[shape_len].y = r.vertex_y;
                    shape_len++;
                end else begin
                    res.append_dropped = 1'b1;
                    shape_overflow = 1'b1;
                end
                pending_res.push_back(res);
            end
            CMD_TEST: begin
                res.overlaps = box_overlaps_shape(r);
                res.append_dropped = shape_overflow;
                pending_res.push_back(res);
            end
            default: ;
        endcase
    endtask

    // Result checker: the block cannot be stalled, so sample every strobe.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_res.size() == 0) begin
                report_mismatch("unexpected result", o_res, '0);
            end else begin
                t_res want;
                want = pending_res.pop_front();
                if (o_res.overlaps !== want.overlaps)
                    report_mismatch("overlaps", o_res, want);
                else if (o_res.append_dropped !== want.append_dropped)
                    report_mismatch("append_dropped", o_res, want);
            end
        end
    end

    // Watchdog: cycles without an accepted request or result.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("polygon_quad_overlap_test_tb NOT OK");
            $finish;
        end
    end

    // Sends one request after a random gap, waits for its acceptance.
    // Start stays high into a back-to-back request; the caller drops it at the end.
    task automatic send_request(input t_req r);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req <= r;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        predict_request(r);
    endtask

    function automatic t_req blank_req(input t_cmd c);
        t_req r;
        r = '0;
        r.cmd = c;
        return r;
    endfunction

    function automatic t_req append_req(input int x, input int y);
        t_req r;
        r = blank_req(CMD_APPEND);
        r.vertex_x = x;
        r.vertex_y = y;
        return r;
    endfunction

    function automatic t_req box_req(input int x0, input int y0, input int x1, input int y1,
                                     input int x2, input int y2, input int x3, input int y3);
        t_req r;
        r = blank_req(CMD_TEST);
        r.corner0_x = x0; r.corner0_y = y0;
        r.corner1_x = x1; r.corner1_y = y1;
        r.corner2_x = x2; r.corner2_y = y2;
        r.corner3_x = x3; r.corner3_y = y3;
        return r;
    endfunction

    function automatic int pick_coord(input int center, input bit wide);
        if (wide) return int'($urandom());
        return center + $signed($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
    endfunction

    // Random axis-free box around a center, sometimes with fully random corners.
    function automatic t_req random_box(input int cx, input int cy);
        bit wide;
        t_req r;
        wide = ($urandom_range(0, 9) == 0);
        r = box_req(pick_coord(cx, wide), pick_coord(cy, wide), pick_coord(cx, wide),
                    pick_coord(cy, wide), pick_coord(cx, wide), pick_coord(cy, wide),
                    pick_coord(cx, wide), pick_coord(cy, wide));
        return r;
    endfunction

    // Directed rows; want_ovl < 0 means the predictor alone decides.
    typedef struct {
        t_req req;
        int   want_ovl;
        int   want_drop;
    } dir_row_t;

    dir_row_t dir_rows[$];
    int       sent_items;

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req = '0;
        fail_count = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        shape_len = 0;
        shape_overflow = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset: empty and single-point polygons never overlap.
        dir_rows.push_back('{box_req(0, 0, 256, 0, 256, 256, 0, 256), 0, 0});
        dir_rows.push_back('{append_req(32'sh7fffffff, 32'sh80000000), 0, 0});
        dir_rows.push_back('{box_req(-1, -1, 1, -1, 1, 1, -1, 1), 0, 0});
        // Square with extreme corners.
        dir_rows.push_back('{append_req(32'sh80000000, 32'sh80000000), 0, 0});
        dir_rows.push_back('{append_req(32'sh80000000, 32'sh7fffffff), 0, 0});
        dir_rows.push_back('{append_req(32'sh7fffffff, 32'sh7fffffff), 0, 0});
        dir_rows.push_back('{box_req(0, 0, 256, 0, 256, 256, 0, 256), -1, 0});
        dir_rows.push_back('{box_req(32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                                     32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                                     32'sh80000000, 32'sh7fffffff), -1, 0});
        // Unused command and clear give nothing.
        dir_rows.push_back('{blank_req(CMD_NONE), -1, -1});
        dir_rows.push_back('{blank_req(CMD_CLEAR), -1, -1});
        // Degenerate polygon: two equal points, and a degenerate box.
        dir_rows.push_back('{append_req(1000, 1000), 0, 0});
        dir_rows.push_back('{append_req(1000, 1000), 0, 0});
        dir_rows.push_back('{box_req(1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000), -1, 0});
        dir_rows.push_back('{append_req(3000, 1000), 0, 0});
        dir_rows.push_back('{box_req(2000, 0, 2000, 2000, 2000, 2000, 2000, 0), -1, 0});
        dir_rows.push_back('{box_req(500, 500, 4000, 500, 4000, 1500, 500, 1500), -1, 0});
        dir_rows.push_back('{blank_req(CMD_CLEAR), -1, -1});

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].req);
            if (dir_rows[i].want_ovl >= 0 && pending_res.size() > 0) begin
                if (pending_res[$].overlaps !== dir_rows[i].want_ovl[0] ||
                    pending_res[$].append_dropped !== dir_rows[i].want_drop[0])
                    report_mismatch("directed row", pending_res[$], '0);
            end
        end
        sent_items = dir_rows.size();

        // Random part: mostly polygons near a center tested with nearby boxes,
        // with overfilling and unused commands mixed in; each polygon starts with a clear.
        while (sent_items < 1000) begin
            int cx, cy, npts, ntests;
            t_req r;
            cx = $signed($urandom()) >>> 2;
            cy = $signed($urandom()) >>> 2;
            npts = ($urandom_range(0, 9) == 0) ? $urandom_range(60, MaxVertices + 4)
                                               : $urandom_range(0, 8);
            send_request(blank_req(CMD_CLEAR));
            sent_items++;
            for (int p = 0; p < npts; p++) begin
                r = append_req(pick_coord(cx, $urandom_range(0, 19) == 0),
                               pick_coord(cy, $urandom_range(0, 19) == 0));
                if ($urandom_range(0, 7) == 0) begin
                    r.corner0_x = $urandom();
                    r.corner3_y = $urandom();
                end
                send_request(r);
                sent_items++;
                if ($urandom_range(0, 40) == 0) begin
                    send_request(blank_req(CMD_NONE));
                end
            end
            ntests = $urandom_range(1, 6);
            for (int t = 0; t < ntests; t++) begin
                r = random_box(cx, cy);
                r.vertex_x = $urandom();
                r.vertex_y = $urandom();
                send_request(r);
                sent_items++;
            end
        end
        i_start <= 1'b0;

        // Drain: wait for every result, then a little longer for stray strobes.
        while (pending_res.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_res.size() == 0)
            $display("polygon_quad_overlap_test_tb OK");
        else
            $display("polygon_quad_overlap_test_tb NOT OK");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+design
design/pqot_pkg.sv
design/pqot_datapath.sv
design/pqot_ctrl.sv
design/polygon_quad_overlap_test.sv
bench/polygon_quad_overlap_test_tb.sv
